// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b at the next clock
`define CHK_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("check failed");
// assert that a implies b in the same clock
`define CHK_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("check failed");
`endif

// ===== design/bpfs_pkg.sv =====
// shared types, constants and the rounding multiply for the particle frame step
// no dependencies
`default_nettype none
package bpfs_pkg;
	localparam int unsigned ParticlesDefault = 12;
	localparam logic signed [31:0] KInv   = -32'sd58982;
	localparam logic signed [31:0] KDecay = 32'sd64225;
	localparam logic signed [31:0] KInvD  = -32'sd52429;
	localparam logic [31:0] KGrav   = 32'd5243;
	localparam logic [31:0] KMax    = 32'h0010_0000;
	localparam logic [31:0] KSpawnY = 32'h0008_0000;
	localparam logic [15:0] FrameLimitReset = 16'd300;
	localparam logic CfgGravity = 1'b0;
	localparam logic CfgLimit   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIN, ST_READ, ST_ADD, ST_BX, ST_BY, ST_BX2, ST_BY2,
		ST_DX, ST_DY, ST_EMIT, ST_WAIT
	} state_t;

	// multiplier operand select
	typedef enum logic [2:0] {
		M_VX_INV, M_VY_INV, M_VY_INVD, M_VX_DEC, M_VY_DEC, M_SPAWN
	} mop_t;

	typedef struct packed {
		logic   load;     // load slot from store
		logic   add;      // position += velocity
		logic   mul;      // multiply and write back
		mop_t   mop;
		logic   clamp;    // apply clamp with multiply
		logic   spawn;    // write spawn values
		logic   store;    // write slot back
		logic   grav;     // add gravity
		logic   kill;
	} cmd_t;

	typedef struct packed {
		logic alive;
		logic x_hi, y_hi, x_lo, y_lo;
		logic die;
	} sts_t;

	// 16.16 product, round half away from zero
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic signed [31:0] k);
		logic signed [63:0] p;
		logic [63:0] m;
		logic [63:0] r;
		p = $signed(a) * k;
		m = p[63] ? (64'd0 - p) : p;
		r = (m + 64'h8000) >> 16;
		if (p[63]) r = 64'd0 - r;
		return r[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/bpfs_if.sv =====
// valid/ready channel interfaces for the particle frame step
// no dependencies
`default_nettype none
interface bpfs_in_if;
	logic valid;
	logic ready;
	logic [15:0] frame_count;
	logic [16:0] rand_vel_x;
	logic [16:0] rand_vel_y;
	logic [5:0] rand_life;
	modport source (output valid, frame_count, rand_vel_x, rand_vel_y, rand_life, input ready);
	modport sink (input valid, frame_count, rand_vel_x, rand_vel_y, rand_life, output ready);
endinterface

interface bpfs_out_if;
	logic valid;
	logic ready;
	logic [3:0] slot;
	logic draw_valid;
	logic signed [31:0] x_start;
	logic signed [31:0] y_start;
	logic signed [31:0] x_end;
	logic signed [31:0] y_end;
	logic odd_color;
	logic finished;
	logic last;
	modport source (output valid, slot, draw_valid, x_start, y_start, x_end, y_end, odd_color,
		finished, last, input ready);
	modport sink (input valid, slot, draw_valid, x_start, y_start, x_end, y_end, odd_color,
		finished, last, output ready);
endinterface

interface bpfs_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/bpfs_datapath.sv =====
// particle store, one rounding multiplier and the position/velocity registers
// depends on bpfs_pkg
`default_nettype none
module bpfs_datapath import bpfs_pkg::*; #(
	parameter int unsigned PARTICLES = ParticlesDefault,
	localparam int unsigned SW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic [SW-1:0] slot_idx,
	input  wire logic clear_all,
	input  wire logic [16:0] rvx,
	input  wire logic [16:0] rvy,
	input  wire logic [5:0] rlife,
	output sts_t sts,
	output logic [31:0] px,
	output logic [31:0] py,
	output logic [31:0] ex,
	output logic [31:0] ey
);
	logic [31:0] mem_px [PARTICLES];
	logic [31:0] mem_py [PARTICLES];
	logic [31:0] mem_vx [PARTICLES];
	logic [31:0] mem_vy [PARTICLES];
	logic [5:0]  mem_life [PARTICLES];
	logic [PARTICLES-1:0] alive_q;
	logic [31:0] px_q, py_q, vx_q, vy_q;
	logic [5:0] life_q;
	logic signed [31:0] mk;
	logic [31:0] ma;
	logic [31:0] prod;

	// multiplier operand select
	always_comb begin
		case (cmd.mop)
			M_VX_INV:  begin ma = vx_q; mk = KInv; end
			M_VY_INV:  begin ma = vy_q; mk = KInv; end
			M_VY_INVD: begin ma = vy_q; mk = KInvD; end
			M_VX_DEC:  begin ma = vx_q; mk = KDecay; end
			M_VY_DEC:  begin ma = vy_q; mk = KDecay; end
			M_SPAWN:   begin ma = {15'd0, rvy}; mk = KInv; end
			default:   begin ma = vx_q; mk = KDecay; end
		endcase
	end
	assign prod = fmul(ma, mk);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= mem_px[slot_idx];
			py_q <= mem_py[slot_idx];
			vx_q <= mem_vx[slot_idx];
			vy_q <= mem_vy[slot_idx];
			life_q <= mem_life[slot_idx];
		end else if (cmd.add) begin
			px_q <= px_q + vx_q;
			py_q <= py_q + vy_q;
		end else if (cmd.mul) begin
			case (cmd.mop)
				M_VX_INV: begin
					vx_q <= prod;
					if (cmd.clamp) px_q <= sts.x_hi ? KMax : 32'd0;
				end
				M_VY_INV, M_VY_INVD: begin
					vy_q <= prod;
					if (cmd.clamp) py_q <= sts.y_hi ? KMax : 32'd0;
				end
				M_VX_DEC: vx_q <= prod;
				M_VY_DEC: vy_q <= cmd.grav ? prod + KGrav : prod;
				default: vy_q <= prod;
			endcase
		end
	end

	// slot store
	always_ff @(posedge clk) begin
		if (cmd.spawn) begin
			mem_px[slot_idx] <= 32'd0;
			mem_py[slot_idx] <= KSpawnY;
			mem_vx[slot_idx] <= {15'd0, rvx};
			mem_vy[slot_idx] <= prod;
			mem_life[slot_idx] <= rlife;
		end else if (cmd.store) begin
			mem_px[slot_idx] <= px_q;
			mem_py[slot_idx] <= py_q;
			mem_vx[slot_idx] <= vx_q;
			mem_vy[slot_idx] <= vy_q;
			mem_life[slot_idx] <= life_q - 6'd1;
		end
	end

	// alive bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (clear_all) begin
			alive_q <= alive_q;
		end else if (cmd.spawn) begin
			alive_q[slot_idx] <= 1'b1;
		end else if (cmd.kill) begin
			alive_q[slot_idx] <= 1'b0;
		end
	end

	assign sts.alive = alive_q[slot_idx];
	assign sts.x_hi = $signed(px_q) > $signed(KMax);
	assign sts.y_hi = $signed(py_q) > $signed(KMax);
	assign sts.x_lo = px_q[31];
	assign sts.y_lo = py_q[31];
	assign sts.die = life_q <= 6'd1;
	assign px = px_q;
	assign py = py_q;
	assign ex = px_q + {vx_q[30:0], 1'b0};
	assign ey = py_q + {vy_q[30:0], 1'b0};
endmodule
`default_nettype wire

// ===== design/bpfs_ctrl.sv =====
// sequencer walking slots and issuing datapath commands
// depends on bpfs_pkg
`default_nettype none
module bpfs_ctrl import bpfs_pkg::*; #(
	parameter int unsigned PARTICLES = ParticlesDefault,
	localparam int unsigned SW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic over,
	input  wire logic grav,
	input  wire sts_t sts,
	input  wire logic out_ready,
	output cmd_t cmd,
	output logic [SW-1:0] slot_idx,
	output logic busy,
	output logic out_valid,
	output logic out_fin,
	output logic out_draw,
	output logic out_last
);
	state_t state_q, state_d;
	logic [SW-1:0] slot_q;
	logic spawned_q, draw_q;
	logic is_last;

	assign is_last = slot_q == SW'(PARTICLES - 1);
	assign slot_idx = slot_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = over ? ST_FIN : ST_READ;
			ST_FIN:  if (out_ready) state_d = ST_IDLE;
			ST_READ: state_d = sts.alive ? ST_ADD : ST_EMIT;
			ST_ADD:  state_d = grav ? ST_BX : ST_DX;
			ST_BX:   state_d = ST_BY;
			ST_BY:   state_d = ST_BX2;
			ST_BX2:  state_d = ST_BY2;
			ST_BY2:  state_d = ST_DX;
			ST_DX:   state_d = ST_DY;
			ST_DY:   state_d = ST_EMIT;
			ST_EMIT: state_d = ST_WAIT;
			ST_WAIT: if (out_ready) state_d = is_last ? ST_IDLE : ST_READ;
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.mop = M_VX_DEC;
		case (state_q)
			ST_READ: begin
				cmd.load = sts.alive;
				cmd.spawn = !sts.alive && !spawned_q;
				cmd.mop = M_SPAWN;
			end
			ST_ADD: cmd.add = 1'b1;
			ST_BX: begin
				cmd.mul = sts.x_hi; cmd.clamp = 1'b1; cmd.mop = M_VX_INV;
			end
			ST_BY: begin
				cmd.mul = sts.y_hi; cmd.clamp = 1'b1; cmd.mop = M_VY_INVD;
			end
			ST_BX2: begin
				cmd.mul = sts.x_lo; cmd.clamp = 1'b1; cmd.mop = M_VX_INV;
			end
			ST_BY2: begin
				cmd.mul = sts.y_lo; cmd.clamp = 1'b1; cmd.mop = M_VY_INV;
			end
			ST_DX: cmd.mul = 1'b1;
			ST_DY: begin
				cmd.mul = 1'b1; cmd.mop = M_VY_DEC; cmd.grav = grav;
			end
			ST_EMIT: begin
				cmd.store = draw_q;
				cmd.kill = draw_q && sts.die;
			end
			default: cmd = cmd;
		endcase
	end

	// slot walk and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= '0;
			spawned_q <= 1'b0;
			draw_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				slot_q <= '0;
				spawned_q <= 1'b0;
			end
			if (state_q == ST_READ) begin
				draw_q <= sts.alive;
				if (!sts.alive) spawned_q <= 1'b1;
			end
			if (state_q == ST_WAIT && out_ready && !is_last) slot_q <= slot_q + 1'b1;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign out_valid = state_q == ST_FIN || state_q == ST_WAIT;
	assign out_fin = state_q == ST_FIN;
	assign out_draw = state_q == ST_WAIT && draw_q;
	assign out_last = state_q == ST_FIN || is_last;
endmodule
`default_nettype wire

// ===== design/bouncing_particle_frame_step_top.sv =====
// a finished frame gives its one request in the cycle after acceptance; otherwise one
// request per slot, held until taken: a dead slot steps read, emit, wait; a live one read,
// add, bounce x, y, x, y (gravity only), decay x, y, emit, wait (one shared rounding multiplier,
// used serially); the next frame is taken only after the last request leaves and idle returns
// reset: asynchronous, clears alive bits, sequencer and config (gravity on, limit 300)
// top level joining config registers, sequencer and datapath; depends on bpfs_pkg, bpfs_if
`default_nettype none
module bouncing_particle_frame_step_top import bpfs_pkg::*; #(
	parameter int unsigned PARTICLES = ParticlesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	bpfs_in_if.sink in_ch,
	bpfs_out_if.source out_ch,
	bpfs_cfg_if.sink cfg
);
	localparam int unsigned SW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	logic grav_q;
	logic [15:0] limit_q;
	logic [16:0] rvx_q, rvy_q;
	logic [5:0] rlife_q;
	cmd_t cmd;
	sts_t sts;
	logic [SW-1:0] slot_idx;
	logic busy, o_fin, o_draw;
	logic [31:0] px, py, ex, ey;
	logic in_fire;

	assign in_ch.ready = !busy;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 1'b1;
			limit_q <= FrameLimitReset;
		end else if (cfg.valid) begin
			if (cfg.index == CfgGravity) grav_q <= cfg.data[0];
			else limit_q <= cfg.data;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rvx_q <= in_ch.rand_vel_x;
			rvy_q <= in_ch.rand_vel_y;
			rlife_q <= in_ch.rand_life;
		end
	end

	bpfs_ctrl #(.PARTICLES(PARTICLES)) u_ctrl (
		.clk, .arst_n, .in_fire,
		.over(in_ch.frame_count > limit_q),
		.grav(grav_q), .sts, .out_ready(out_ch.ready), .cmd, .slot_idx, .busy,
		.out_valid(out_ch.valid), .out_fin(o_fin), .out_draw(o_draw), .out_last(out_ch.last)
	);

	bpfs_datapath #(.PARTICLES(PARTICLES)) u_dp (
		.clk, .arst_n, .cmd, .slot_idx, .clear_all(1'b0), .rvx(rvx_q), .rvy(rvy_q),
		.rlife(rlife_q), .sts, .px, .py, .ex, .ey
	);

	// result fields
	assign out_ch.finished = o_fin;
	assign out_ch.draw_valid = o_draw;
	assign out_ch.slot = o_fin ? 4'd0 : 4'(slot_idx);
	assign out_ch.odd_color = !o_fin && slot_idx[0];
	assign out_ch.x_start = o_draw ? px : 32'd0;
	assign out_ch.y_start = o_draw ? py : 32'd0;
	assign out_ch.x_end = o_draw ? ex : 32'd0;
	assign out_ch.y_end = o_draw ? ey : 32'd0;
endmodule
`default_nettype wire

// ===== design/bpfs_checker.sv =====
// port-level checks for the particle frame step, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module bpfs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic finished,
	input wire logic last,
	input wire logic draw_valid
);
	// finished request is always the last one
	`CHK_SAME(a_fin_last, clk, arst_n, out_valid && finished, last)
	// finished request never draws
	`CHK_SAME(a_fin_nodraw, clk, arst_n, out_valid && finished, !draw_valid)
	// no new frame while a request is waiting
	`CHK_SAME(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// a taken frame occupies the block next cycle
	`CHK_NEXT(a_busy_after, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind bouncing_particle_frame_step_top bpfs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .finished(out_ch.finished),
	.last(out_ch.last), .draw_valid(out_ch.draw_valid)
);
`default_nettype wire
